// ===== sv/lrukv_pkg.sv =====
// Package: shared constants, types and codes of the LRU key-value cache.
`timescale 1ns / 1ps
package lrukv_pkg;
    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int SLOT_W      = 4;
    localparam int CFG_W       = 5;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

    // register index, taken from paddr[2]
    localparam logic REG_ACTIVE = 1'b0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    // priority flags rippling from cell 0 upward
    typedef struct packed {
        logic match_seen;
        logic free_seen;
        logic victim_seen;
    } t_chain;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic look;
        logic commit;
        logic is_put;
        logic hit;
        logic free_any;
        logic age_all;
    } t_ctl;
endpackage

// ===== sv/lrukv_if.sv =====
// Interfaces: request and response channels of the LRU key-value cache.
`timescale 1ns / 1ps
interface lru_req_if import lrukv_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] write_value;

    modport source (output valid, cmd, key, write_value, input ready);
    modport sink (input valid, cmd, key, write_value, output ready);
endinterface

interface lru_rsp_if import lrukv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              hit;
    logic [VAL_W-1:0]  read_value;
    logic [SLOT_W-1:0] slot_used;

    modport source (output valid, hit, read_value, slot_used, input ready);
    modport sink (input valid, hit, read_value, slot_used, output ready);
endinterface

// ===== sv/lru_key_value_cache.sv =====
// Top level: fully associative key-value cache with true LRU replacement.
//
//  port       dir   handshake           payload
//  i_req      in    valid/ready         cmd, key, write_value
//  o_rsp      out   valid/ready         hit, read_value, slot_used
//  APB        in    psel/penable/pwrite active_entries at byte address 0
//
//  Each request passes through a lookup cycle, in which the cell chain compares
//  the key and collects the rank vector, then an update state that picks the
//  slot and re-ranks the cells on a hit or a put. Responses wait in an output
//  register; a new request is taken in the update state unless it is still full.
//  Reset (synchronous, active low) clears valid bits, ranks and the capacity to 16.
`timescale 1ns / 1ps
module lru_key_value_cache import lrukv_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    lru_req_if.sink               i_req,
    lru_rsp_if.source             o_rsp
);
    localparam int RW = $clog2(ENTRIES);

    t_state r_state;
    t_state n_state;

    logic             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_wval;
    logic             r_hit;
    logic             r_free_any;
    logic [RW-1:0]    r_max_rank;
    logic [RW-1:0]    r_hit_rank;
    logic [CFG_W-1:0] r_active;

    logic              r_out_valid;
    logic              r_out_hit;
    logic [VAL_W-1:0]  r_out_read;
    logic [SLOT_W-1:0] r_out_slot;

    logic              w_done;
    logic              w_in_ready;
    logic              w_in_fire;
    t_ctl              w_ctl;
    logic [RW-1:0]     w_limit;
    logic [RW-1:0]     w_max_rank;
    logic [VAL_W-1:0]  w_rd;
    logic [SLOT_W-1:0] w_slot;

    t_chain             w_chain    [ENTRIES+1];
    logic [ENTRIES-1:0] w_ages     [ENTRIES+1];
    logic [RW-1:0]      w_hit_rank [ENTRIES+1];
    logic [ENTRIES-1:0] w_sel;
    logic [VAL_W-1:0]   w_val      [ENTRIES];
    logic [ENTRIES-1:0] w_active;

    assign w_chain[0]    = '0;
    assign w_ages[0]     = '0;
    assign w_hit_rank[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        // capacity 0 acts as 1; anything above ENTRIES covers all cells
        assign w_active[g] = (g == 0) || (g < int'(r_active));

        lrukv_cell #(.ENTRIES(ENTRIES)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_active   (w_active[g]),
            .i_key      (r_key),
            .i_wval     (r_wval),
            .i_max_rank (r_max_rank),
            .i_limit    (w_limit),
            .i_chain    (w_chain[g]),
            .o_chain    (w_chain[g+1]),
            .i_ages     (w_ages[g]),
            .o_ages     (w_ages[g+1]),
            .i_hit_rank (w_hit_rank[g]),
            .o_hit_rank (w_hit_rank[g+1]),
            .o_sel      (w_sel[g]),
            .o_value    (w_val[g])
        );
    end

    always_comb begin
        w_max_rank = '0;
        for (int j = 0; j < ENTRIES; j++) begin
            if (w_ages[ENTRIES][j]) begin
                w_max_rank = RW'(j);
            end
        end
    end

    always_comb begin
        w_rd   = '0;
        w_slot = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_sel[i]) begin
                w_rd   = w_rd | w_val[i];
                w_slot = w_slot | SLOT_W'(i);
            end
        end
    end

    assign w_done    = (r_state == ST_UPD) && (!r_out_valid || o_rsp.ready);
    assign w_in_fire = i_req.valid && w_in_ready;
    assign w_limit   = r_hit ? r_hit_rank : r_max_rank;

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_done) n_state = w_in_fire ? ST_LOOK : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb begin
        w_in_ready      = 1'b0;
        w_ctl           = '0;
        w_ctl.is_put    = (r_cmd == CMD_PUT);
        w_ctl.hit       = r_hit;
        w_ctl.free_any  = r_free_any;
        w_ctl.age_all   = !r_hit && r_free_any;
        case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_LOOK: begin
                w_ctl.look = 1'b1;
            end
            ST_UPD: begin
                w_in_ready   = w_done;
                w_ctl.commit = w_done;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hit       <= 1'b0;
            r_free_any  <= 1'b0;
            r_active    <= ACTIVE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.look) begin
                r_hit      <= w_chain[ENTRIES].match_seen;
                r_free_any <= w_chain[ENTRIES].free_seen;
            end
            if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE)) begin
                r_active <= pwdata[CFG_W-1:0];
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd  <= i_req.cmd;
            r_key  <= i_req.key;
            r_wval <= i_req.write_value;
        end
        if (w_ctl.look) begin
            r_max_rank <= w_max_rank;
            r_hit_rank <= w_hit_rank[ENTRIES];
        end
        if (w_done) begin
            r_out_hit  <= r_hit;
            r_out_read <= (r_cmd == CMD_GET && r_hit) ? w_rd : '0;
            r_out_slot <= w_slot;
        end
    end

    assign i_req.ready      = w_in_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_read;
    assign o_rsp.slot_used  = r_out_slot;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ACTIVE) ? APB_DATA_W'(r_active) : '0;

    a_sel_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one slot selected");

    a_look_to_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK) |=> (r_state == ST_UPD))
        else $error("lookup not followed by update");

    a_put_selects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_cmd == CMD_PUT) |-> $onehot(w_sel))
        else $error("put commits without exactly one slot");

    a_get_selects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && r_cmd == CMD_GET) |-> ($countones(w_sel) == (r_hit ? 1 : 0)))
        else $error("get selection disagrees with hit");
endmodule

// ===== sv/lrukv_cell.sv =====
// Cache slot cell: key, value, valid and recency rank, with chained priority flags.
`timescale 1ns / 1ps
module lrukv_cell import lrukv_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF,
    localparam int RW = $clog2(ENTRIES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  logic               i_active,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VAL_W-1:0]   i_wval,
    input  logic [RW-1:0]      i_max_rank,
    input  logic [RW-1:0]      i_limit,
    input  t_chain             i_chain,
    output t_chain             o_chain,
    input  logic [ENTRIES-1:0] i_ages,
    output logic [ENTRIES-1:0] o_ages,
    input  logic [RW-1:0]      i_hit_rank,
    output logic [RW-1:0]      o_hit_rank,
    output logic               o_sel,
    output logic [VAL_W-1:0]   o_value
);
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic             r_valid;
    logic [RW-1:0]    r_rank;
    logic             r_match_sel;
    logic             r_free_sel;

    logic w_live;
    logic w_match;
    logic w_first_match;
    logic w_free;
    logic w_first_free;
    logic w_victim;
    logic w_age;

    assign w_live        = i_active && r_valid;
    assign w_match       = w_live && (r_key == i_key);
    assign w_first_match = w_match && !i_chain.match_seen;
    assign w_free        = i_active && !r_valid;
    assign w_first_free  = w_free && !i_chain.free_seen;
    assign w_victim      = w_live && (r_rank == i_max_rank) && !i_chain.victim_seen;

    assign o_chain.match_seen  = i_chain.match_seen || w_match;
    assign o_chain.free_seen   = i_chain.free_seen || w_free;
    assign o_chain.victim_seen = i_chain.victim_seen || w_victim;

    assign o_ages     = i_ages | (w_live ? (ENTRIES'(1) << r_rank) : '0);
    assign o_hit_rank = i_hit_rank | (w_first_match ? r_rank : '0);

    assign o_sel = i_ctl.hit ? r_match_sel
                 : (i_ctl.is_put && (i_ctl.free_any ? r_free_sel : w_victim));

    // ranks saturate at the oldest code
    assign w_age = r_valid && (i_ctl.age_all || (r_rank < i_limit))
                && (r_rank != RW'(ENTRIES - 1));

    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_rank      <= '0;
            r_match_sel <= 1'b0;
            r_free_sel  <= 1'b0;
        end else begin
            if (i_ctl.look) begin
                r_match_sel <= w_first_match;
                r_free_sel  <= w_first_free;
            end
            if (i_ctl.commit && (i_ctl.hit || i_ctl.is_put)) begin
                if (o_sel) begin
                    r_valid <= 1'b1;
                    r_rank  <= '0;
                end else if (w_age) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && i_ctl.is_put && o_sel) begin
            r_key   <= i_key;
            r_value <= i_wval;
        end
    end
endmodule
